// ===== rtl/rgbwfb_pkg.sv =====
package rgbwfb_pkg;

	localparam int CNT_W      = 6;
	localparam int BYTE_W     = 8;
	localparam int BRT_W      = 8;
	localparam int WORD_W     = 32;
	localparam int STEP_W     = 16;
	localparam int PIDX_W     = 8;
	localparam int OP_W       = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;
	localparam int DEF_MAX_PIXELS = 63;
	localparam logic [BRT_W-1:0] BRIGHT_RESET = 8'd255;

	typedef enum logic [OP_W-1:0] {
		OP_SET  = 2'd0,
		OP_FILL = 2'd1,
		OP_SHOW = 2'd2,
		OP_ROT  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT  = 1'b0,
		REG_BRIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_FILL,
		ST_RD,
		ST_SHOW,
		ST_LATCH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

	// floor(x * b / 255) via reciprocal form, exact for 16-bit products
	function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] x,
		input logic [BRT_W-1:0] b);
		logic [2*BYTE_W-1:0] prod;
		logic [2*BYTE_W:0]   acc;
		prod = {{BYTE_W{1'b0}}, x} * {{(2*BYTE_W-BRT_W){1'b0}}, b};
		acc  = {1'b0, prod} + 17'd1 + {9'd0, prod[2*BYTE_W-1:BYTE_W]};
		return acc[2*BYTE_W-1:BYTE_W];
	endfunction

endpackage

// ===== rtl/rgbwfb_rem_unit.sv =====
module rgbwfb_rem_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rgbwfb_pkg::STEP_W-1:0]        dividend,
	input  logic [rgbwfb_pkg::CNT_W-1:0]         divisor,
	output rgbwfb_pkg::rem_stat_t                stat,
	output logic [rgbwfb_pkg::CNT_W-1:0]         rem
);
	import rgbwfb_pkg::*;

	localparam int BIT_CNT_W = $clog2(STEP_W);

	logic                  busy_q;
	logic                  done_q;
	logic [BIT_CNT_W-1:0]  bit_q;
	logic [STEP_W-1:0]     dvd_q;
	logic [CNT_W-1:0]      div_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W:0]        trial;
	logic [CNT_W:0]        diff;
	logic [CNT_W-1:0]      rem_next;

	// one restoring step per cycle, one dividend bit each
	always_comb begin
		trial = {rem_q, dvd_q[STEP_W-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = diff[CNT_W-1:0];
		end else begin
			rem_next = trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == BIT_CNT_W'(STEP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[STEP_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("remainder done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("remainder unit did not start");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < div_q)) else $error("partial remainder out of range");
`endif

endmodule

// ===== rtl/rgbw_pixel_frame_buffer_core.sv =====
// channel | dir | tdata fields (low bit up)                                 | tuser     | tlast
// s_axis  | in  | operation 2, pixel_index 8, red_in 8, green_in 8,          | -         | -
//         |     | blue_in 8, white_in 8, rotate_steps 16, zero pad 6         |           |
// m_axis  | out | green_out 8, red_out 8, blue_out 8, white_out 8            | latch_gap | last_item
// cfg     | in  | cfg_we, cfg_index (0 pixel_count, 1 brightness), cfg_data 8
//
// set pixel writes the store on acceptance, staying idle; rotate runs one remainder step per cycle
// fill sends one pixel per cycle while m_tready allows, plus the latch item, writing the store as it goes
// show does a registered store read per pixel, then scaling into the output register
// reset clears per-pixel valid bits at once, so no clearing pass; invalid pixels read as zero
// a stalled m_tready holds the sequencer; s_tready is high only while idle
module rgbw_pixel_frame_buffer_core #(
	parameter int MAX_PIXELS = rgbwfb_pkg::DEF_MAX_PIXELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [rgbwfb_pkg::IN_DATA_W-1:0]      s_tdata,   // operation, pixel_index, red, green, blue, white, rotate_steps
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [rgbwfb_pkg::OUT_DATA_W-1:0]     m_tdata,   // green, red, blue, white
	output logic                                  m_tuser,   // latch_gap
	output logic                                  m_tlast,
	input  logic                                  cfg_we,
	input  logic [rgbwfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgbwfb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rgbwfb_pkg::*;

	localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

	typedef enum logic [1:0] {
		OSEL_RAW,
		OSEL_SCALED,
		OSEL_LATCH
	} out_sel_t;

	state_t              state_q;
	state_t              state_d;

	logic [CNT_W-1:0]    count_q;
	logic [BRT_W-1:0]    bright_q;
	logic [CNT_W-1:0]    base_q;
	logic [CNT_W-1:0]    n_act;

	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    slot_q;
	logic [WORD_W-1:0]   word_q;
	logic                last_px;

	logic [WORD_W-1:0]   mem_q [MAX_PIXELS];
	logic [MAX_PIXELS-1:0] valid_q;
	logic [WORD_W-1:0]   rd_q;
	logic                rv_q;

	logic                m_tvalid_q;
	logic [WORD_W-1:0]   out_data_q;
	logic                out_latch_q;
	logic                out_last_q;
	logic                out_free;

	logic                accept;
	op_t                 in_op;
	logic [PIDX_W-1:0]   in_idx;
	logic [WORD_W-1:0]   in_word;
	logic [STEP_W-1:0]   in_steps;

	logic [CNT_W-1:0]    idx_c;
	logic [CNT_W:0]      set_sum;
	logic [CNT_W-1:0]    set_slot;
	logic [CNT_W:0]      rot_sum;
	logic [CNT_W-1:0]    rot_base;

	logic [WORD_W-1:0]   rd_word;
	logic [WORD_W-1:0]   scaled_word;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                mem_re;
	logic                out_load;
	out_sel_t            out_sel;
	logic                seq_clr;
	logic                seq_inc;
	logic                word_ld;
	logic                rem_start;
	logic                base_upd;

	rem_stat_t           rem_stat;
	logic [CNT_W-1:0]    rem_val;

	assign in_op    = op_t'(s_tdata[1:0]);
	assign in_idx   = s_tdata[9:2];
	assign in_word  = {s_tdata[41:34], s_tdata[33:26], s_tdata[17:10], s_tdata[25:18]};
	assign in_steps = s_tdata[57:42];

	assign n_act    = (count_q > MAX_CNT) ? MAX_CNT : count_q;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_px  = (cnt_q == n_act - 1'b1);

	always_comb begin
		if (in_idx >= {{(PIDX_W-CNT_W){1'b0}}, n_act}) begin
			idx_c = n_act - 1'b1;
		end else begin
			idx_c = in_idx[CNT_W-1:0];
		end
		set_sum = {1'b0, base_q} + {1'b0, idx_c};
		if (set_sum >= {1'b0, n_act}) begin
			set_slot = CNT_W'(set_sum - {1'b0, n_act});
		end else begin
			set_slot = set_sum[CNT_W-1:0];
		end
		rot_sum = {1'b0, base_q} + {1'b0, rem_val};
		if (rot_sum >= {1'b0, n_act}) begin
			rot_base = CNT_W'(rot_sum - {1'b0, n_act});
		end else begin
			rot_base = rot_sum[CNT_W-1:0];
		end
	end

	always_comb begin
		rd_word = rv_q ? rd_q : '0;
		for (int k = 0; k < WORD_W / BYTE_W; k++) begin
			scaled_word[k*BYTE_W +: BYTE_W] = scale_byte(rd_word[k*BYTE_W +: BYTE_W], bright_q);
		end
	end

	rgbwfb_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (in_steps),
		.divisor  (n_act),
		.stat     (rem_stat),
		.rem      (rem_val)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_SET:  state_d = ST_IDLE;
						OP_FILL: state_d = (n_act == '0) ? ST_LATCH : ST_FILL;
						OP_SHOW: state_d = (n_act == '0) ? ST_LATCH : ST_RD;
						OP_ROT:  state_d = (n_act == '0) ? ST_IDLE : ST_ROT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ROT: begin
				if (rem_stat.done) state_d = ST_IDLE;
			end
			ST_FILL: begin
				if (out_free && last_px) state_d = ST_LATCH;
			end
			ST_RD: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_free) state_d = last_px ? ST_LATCH : ST_RD;
			end
			ST_LATCH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = set_slot[IDX_W-1:0];
		mem_wdata = in_word;
		mem_re    = 1'b0;
		out_load  = 1'b0;
		out_sel   = OSEL_LATCH;
		seq_clr   = 1'b0;
		seq_inc   = 1'b0;
		word_ld   = 1'b0;
		rem_start = 1'b0;
		base_upd  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					seq_clr = 1'b1;
					unique case (in_op)
						OP_SET:  mem_we = (n_act != '0);
						OP_FILL: word_ld = 1'b1;
						OP_SHOW: ;
						OP_ROT:  rem_start = (n_act != '0);
						default: ;
					endcase
				end
			end
			ST_ROT: begin
				base_upd = rem_stat.done;
			end
			ST_FILL: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_sel   = OSEL_RAW;
					mem_we    = 1'b1;
					mem_waddr = cnt_q[IDX_W-1:0];
					mem_wdata = word_q;
					seq_inc   = 1'b1;
				end
			end
			ST_RD: begin
				mem_re = 1'b1;
			end
			ST_SHOW: begin
				if (out_free) begin
					out_load = 1'b1;
					out_sel  = OSEL_SCALED;
					seq_inc  = 1'b1;
				end
			end
			ST_LATCH: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			bright_q    <= BRIGHT_RESET;
			base_q      <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			valid_q     <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_COUNT: begin
						count_q <= cfg_data[CNT_W-1:0];
						base_q  <= '0;
					end
					REG_BRIGHT: bright_q <= cfg_data;
					default: ;
				endcase
			end
			if (base_upd) base_q <= rot_base;
			if (seq_clr) begin
				cnt_q  <= '0;
				slot_q <= base_q;
			end else if (seq_inc) begin
				cnt_q  <= cnt_q + 1'b1;
				slot_q <= (slot_q + 1'b1 == n_act) ? '0 : slot_q + 1'b1;
			end
			if (mem_we) valid_q[mem_waddr] <= 1'b1;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) begin
			rd_q <= mem_q[slot_q[IDX_W-1:0]];
			rv_q <= valid_q[slot_q[IDX_W-1:0]];
		end
		if (word_ld) word_q <= in_word;
		if (out_load) begin
			case (out_sel)
				OSEL_RAW: begin
					out_data_q  <= word_q;
					out_latch_q <= 1'b0;
					out_last_q  <= 1'b0;
				end
				OSEL_SCALED: begin
					out_data_q  <= scaled_word;
					out_latch_q <= 1'b0;
					out_last_q  <= 1'b0;
				end
				default: begin
					out_data_q  <= '0;
					out_latch_q <= 1'b1;
					out_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_latch_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_ready_not_rotating: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rem_stat.busy) else $error("input ready during rotate");
	a_latch_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast) else $error("latch item not last");
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_act != '0) |-> (base_q < n_act)) else $error("rotation base out of range");
	a_show_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW && out_free) |=> m_tvalid) else $error("show pixel not presented");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (cnt_q < n_act)) else $error("fill past pixel count");
`endif

endmodule

// ===== tb/rgbw_frame_checker.sv =====
module rgbw_frame_checker
	import rgbwfb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // operation, pixel_index, red, green, blue, white, rotate_steps
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // green, red, blue, white
	input  logic                  m_tuser,   // latch_gap
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    items_due
);

	typedef struct {
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] white;
		logic              latch_gap;
		logic              last_item;
	} wire_item_t;

	logic [WORD_W-1:0] strip_words [DEF_MAX_PIXELS];
	logic [CNT_W-1:0]  strip_len = '0;
	logic [CNT_W-1:0]  base_slot = '0;
	logic [BRT_W-1:0]  bright = BRIGHT_RESET;
	wire_item_t        wire_due [$];
	int                error_total = 0;
	int                due_total = 0;

	assign errors = error_total;
	assign items_due = due_total;

	function automatic logic [BYTE_W-1:0] dim_byte(logic [BYTE_W-1:0] x, bit scaled);
		if (!scaled)
			return x;
		return BYTE_W'((int'(x) * int'(bright)) / 255);
	endfunction

	function automatic void queue_frame(bit scaled);
		int n;
		logic [WORD_W-1:0] word;
		wire_item_t item;
		n = int'(strip_len);
		for (int i = 0; i < n; i++) begin
			word = strip_words[(int'(base_slot) + i) % n];
			item.green = dim_byte(word[7:0], scaled);
			item.red = dim_byte(word[15:8], scaled);
			item.blue = dim_byte(word[23:16], scaled);
			item.white = dim_byte(word[31:24], scaled);
			item.latch_gap = 1'b0;
			item.last_item = 1'b0;
			wire_due.push_back(item);
		end
		item.green = '0;
		item.red = '0;
		item.blue = '0;
		item.white = '0;
		item.latch_gap = 1'b1;
		item.last_item = 1'b1;
		wire_due.push_back(item);
	endfunction

	function automatic void apply_command(logic [IN_DATA_W-1:0] d);
		op_t op;
		int n;
		int idx;
		int steps;
		logic [WORD_W-1:0] word;
		op = op_t'(d[1:0]);
		n = int'(strip_len);
		idx = int'(d[9:2]);
		steps = int'(d[57:42]);
		word = {d[41:34], d[33:26], d[17:10], d[25:18]};
		case (op)
			OP_SET: begin
				if (n != 0) begin
					if (idx >= n)
						idx = n - 1;
					strip_words[(int'(base_slot) + idx) % n] = word;
				end
			end
			OP_FILL: begin
				for (int i = 0; i < n; i++)
					strip_words[i] = word;
				queue_frame(1'b0);
			end
			OP_SHOW: queue_frame(1'b1);
			default: begin
				if (n != 0)
					base_slot = CNT_W'((int'(base_slot) + steps % n) % n);
			end
		endcase
	endfunction

	task automatic check_field(string name, int expected, int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, actual %0d", name, expected, actual);
			error_total++;
		end
	endtask

	task automatic check_transfer();
		wire_item_t want;
		if (wire_due.size() == 0) begin
			$error("unexpected output transfer: tdata %h tuser %b tlast %b",
				m_tdata, m_tuser, m_tlast);
			error_total++;
		end else begin
			want = wire_due.pop_front();
			check_field("green_out", want.green, m_tdata[7:0]);
			check_field("red_out", want.red, m_tdata[15:8]);
			check_field("blue_out", want.blue, m_tdata[23:16]);
			check_field("white_out", want.white, m_tdata[31:24]);
			check_field("latch_gap", want.latch_gap, m_tuser);
			check_field("last_item", want.last_item, m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEF_MAX_PIXELS; i++)
				strip_words[i] = '0;
			strip_len = '0;
			base_slot = '0;
			bright = BRIGHT_RESET;
			wire_due.delete();
			due_total = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_transfer();
			if (s_tvalid && s_tready)
				apply_command(s_tdata);
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_COUNT: begin
						strip_len = cfg_data[CNT_W-1:0];
						base_slot = '0;
					end
					default: bright = cfg_data;
				endcase
			end
			due_total = wire_due.size();
		end
	end

endmodule

// ===== tb/rgbw_pixel_frame_buffer_core_test.sv =====
module rgbw_pixel_frame_buffer_core_test;
	import rgbwfb_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    items_due;

	int tx_idle_pct = 26;
	int rx_idle_pct = 72;
	bit want_hold = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;

	rgbw_pixel_frame_buffer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rgbw_frame_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.items_due(items_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output side backpressure, with one long hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (want_hold && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	task automatic send_cmd(op_t op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
		logic [7:0] bl, logic [7:0] w, logic [15:0] steps);
		bit taken;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, steps, w, bl, g, r, idx, op};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain_frames();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (items_due != 0);
		// rotate produces nothing but keeps the core busy for a while
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		s_tvalid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(int cnt);
		int pick;
		op_t op;
		logic [7:0] idx;
		logic [15:0] steps;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_SET;
		else if (pick < 55)
			op = OP_FILL;
		else if (pick < 80)
			op = OP_SHOW;
		else
			op = OP_ROT;
		if ($urandom_range(0, 3) == 0)
			idx = 8'($urandom_range(0, 255));
		else
			idx = 8'($urandom_range(0, cnt + 1));
		if ($urandom_range(0, 1) == 0)
			steps = 16'($urandom);
		else
			steps = 16'($urandom_range(0, 130));
		send_cmd(op, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), steps);
	endtask

	initial begin
		int cnt;
		logic [7:0] lvl;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strip disabled after reset
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		send_cmd(OP_FILL, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff);
		send_cmd(OP_SET, 8'd0, 8'h11, 8'h22, 8'h33, 8'h44, 16'd0);
		send_cmd(OP_ROT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd5);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);

		drain_frames();
		write_reg(REG_COUNT, 8'd5);
		send_cmd(OP_SET, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 16'd0);
		send_cmd(OP_SET, 8'd255, 8'h01, 8'h02, 8'h03, 8'h04, 16'd0);
		send_cmd(OP_SET, 8'd2, 8'h80, 8'h7f, 8'hc3, 8'h3c, 16'd0);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		send_cmd(OP_ROT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'hffff);
		send_cmd(OP_ROT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd2);
		send_cmd(OP_SET, 8'd1, 8'h55, 8'haa, 8'h0f, 8'hf0, 16'd0);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);

		drain_frames();
		write_reg(REG_BRIGHT, 8'd0);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		drain_frames();
		write_reg(REG_BRIGHT, 8'd128);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		send_cmd(OP_FILL, 8'd0, 8'h12, 8'h34, 8'h56, 8'h78, 16'd0);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);

		// full strip, upper data bits set on the count write
		drain_frames();
		write_reg(REG_COUNT, 8'hff);
		write_reg(REG_BRIGHT, 8'd255);
		send_cmd(OP_FILL, 8'd0, 8'haa, 8'hbb, 8'hcc, 8'hdd, 16'd0);
		send_cmd(OP_SET, 8'd62, 8'h01, 8'h02, 8'h03, 8'h04, 16'd0);
		send_cmd(OP_SET, 8'd63, 8'hfe, 8'hfd, 8'hfc, 8'hfb, 16'd0);
		send_cmd(OP_ROT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'hffff);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);

		drain_frames();
		write_reg(REG_COUNT, 8'd1);
		send_cmd(OP_ROT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd7);
		send_cmd(OP_SET, 8'd200, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 16'd0);
		send_cmd(OP_SHOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);

		for (int chunk = 0; chunk < 12; chunk++) begin
			drain_frames();
			if (chunk < 4) begin
				tx_idle_pct = 26;
				rx_idle_pct = 72;
			end else if (chunk < 8) begin
				tx_idle_pct = 72;
				rx_idle_pct = 26;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (chunk == 3 || chunk == 10)
				cnt = 63;
			else if (chunk == 7)
				cnt = 0;
			else if (chunk == 4)
				cnt = 40;
			else
				cnt = $urandom_range(1, 12);
			if (chunk == 1)
				lvl = 8'd0;
			else if (chunk == 5)
				lvl = 8'd255;
			else
				lvl = 8'($urandom_range(0, 255));
			write_reg(REG_COUNT, {2'($urandom), 6'(cnt)});
			write_reg(REG_BRIGHT, lvl);
			if (chunk == 4)
				want_hold = 1'b1;
			for (int k = 0; k < 32; k++) begin
				if (chunk == 2 && k == 16)
					drain_frames();
				send_random(cnt);
			end
		end

		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (items_due != 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rgbwfb_pkg.sv
rtl/rgbwfb_rem_unit.sv
rtl/rgbw_pixel_frame_buffer_core.sv
tb/rgbw_frame_checker.sv
tb/rgbw_pixel_frame_buffer_core_test.sv
